// File: rtl/core/ksl_pkg.sv
// ----------------------------------------------------------------------------
// ksl_pkg
// Shared types and constants of the keyframe linear sampler: the table entry
// layout, function codes and the quotient digit beat between divider and lerp.
// ----------------------------------------------------------------------------
package ksl_pkg;

   // fixed field widths
   localparam int unsigned WORD_W   = 32;
   localparam int unsigned FRAC_W   = 17;   // Q1.16 fraction, 1.0 included
   localparam int unsigned QCNT_W   = 5;    // counts FRAC_W quotient digits
   localparam int unsigned DIFF_W   = WORD_W + 1;
   localparam int unsigned ACC_W    = 48;   // low bits of (v1-v0)*frac
   localparam int unsigned KCOUNT_W = 7;

   // function codes of a request beat
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   // one table entry as stored in the key memory
   typedef struct packed {
      logic [WORD_W-1:0] key_time;
      logic [WORD_W-1:0] x;
      logic [WORD_W-1:0] y;
      logic [WORD_W-1:0] z;
   } entry_type;

   // one quotient digit, msb first, from the divider
   typedef struct packed {
      logic step;      // a digit is present this cycle
      logic digit;     // quotient bit value
      logic last;      // least significant digit
   } qdigit_type;

endpackage

// File: rtl/core/keyframe_linear_sampler_unit.sv
// ----------------------------------------------------------------------------
// keyframe_linear_sampler_unit
// Keyframe table with linear interpolation of a three-component vector.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid / req_stall): a load beat (func = 0) writes one
//   key entry at key_index and returns nothing; a sample beat (func = 1)
//   returns one rsp beat with out_x/y/z.
//   csr channel (csr_valid / csr_ready): writes key_count, always ready;
//   write it only while the block is idle. Reset sets key_count to 1.
//   A sample reads the first key and returns it when the time is at or
//   before it or only one key is set; otherwise a sequential scan reads one
//   key per cycle from the key memory, which has one write and one read
//   port, up to key key_count - 1. A pair with zero span that brackets the
//   time returns its first entry, and with no bracket the last key is
//   returned; a bracketing pair is interpolated: the fraction and the three
//   products come out of a bit-serial divider feeding three serial lerp
//   units. One sample is in flight at a time: no new beat, sample or load,
//   is accepted until the block is idle again.
//   rsp is a register: a new beat may be accepted while a result waits, and
//   a stalled rsp holds the block before its next result is posted. The key
//   memory is not cleared by reset: read only entries that were loaded.
// ----------------------------------------------------------------------------
module keyframe_linear_sampler_unit
   import ksl_pkg::*;
#(
   parameter int unsigned MAX_KEYS = 64
)
(
   input  logic                     clock,
   input  logic                     reset,
   // request channel
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic                     req_func,
   input  logic [5:0]               req_key_index,
   input  logic [WORD_W-1:0]        req_key_time,
   input  logic signed [WORD_W-1:0] req_key_x,
   input  logic signed [WORD_W-1:0] req_key_y,
   input  logic signed [WORD_W-1:0] req_key_z,
   input  logic [WORD_W-1:0]        req_sample_time,
   // response channel
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic signed [WORD_W-1:0] rsp_out_x,
   output logic signed [WORD_W-1:0] rsp_out_y,
   output logic signed [WORD_W-1:0] rsp_out_z,
   // configuration channel
   input  logic                     csr_valid,
   output logic                     csr_ready,
   input  logic [KCOUNT_W-1:0]      csr_wdata
);

   localparam int unsigned IDX_W = $clog2(MAX_KEYS);
   localparam int unsigned CNT_W = $clog2(MAX_KEYS + 1);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_FIRST = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_MATH  = 5'b01000,
      ST_HOLD  = 5'b10000
   } state_type;

   state_type           state_ff, state_in;
   logic [KCOUNT_W-1:0] kcount_ff, kcount_in;
   logic [IDX_W-1:0]    last_idx_ff, last_idx_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [WORD_W-1:0]   time_ff, time_in;
   entry_type           prev_ff, prev_in;
   entry_type           res_ff, res_in;
   logic                src_math_ff, src_math_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]   rsp_x_ff, rsp_x_in;
   logic [WORD_W-1:0]   rsp_y_ff, rsp_y_in;
   logic [WORD_W-1:0]   rsp_z_ff, rsp_z_in;

   entry_type           key_mem [MAX_KEYS];
   entry_type           rd_data_ff;
   logic [IDX_W-1:0]    rd_addr;
   logic                wr_en;
   logic [IDX_W-1:0]    wr_addr;
   entry_type           wr_data;

   logic                req_accept;
   logic                slot_free;
   logic [CNT_W-1:0]    count_eff;
   logic                bracket;
   logic                start_math;
   logic [WORD_W-1:0]   span;
   logic [WORD_W-1:0]   dt;
   qdigit_type          qdigit;
   logic signed [WORD_W-1:0] lerp_x, lerp_y, lerp_z;

   assign req_accept = req_valid && !req_stall;
   assign req_stall  = state_ff != ST_IDLE;
   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready  = 1'b1;

   // key count clamped to 1..MAX_KEYS
   always_comb begin
      if (kcount_ff == '0) begin
         count_eff = CNT_W'(1);
      end else if (int'(kcount_ff) > MAX_KEYS) begin
         count_eff = CNT_W'(MAX_KEYS);
      end else begin
         count_eff = CNT_W'(kcount_ff);
      end
   end

   // key memory write on a load beat in range
   always_comb begin
      wr_en   = req_accept && (req_func == FUNC_LOAD) && (int'(req_key_index) < MAX_KEYS);
      wr_addr = IDX_W'(req_key_index);
      wr_data = '{key_time: req_key_time, x: req_key_x, y: req_key_y, z: req_key_z};
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= key_mem[rd_addr];
   end

   // pair test against the key just read
   always_comb begin
      bracket    = (prev_ff.key_time <= time_ff) && (time_ff <= rd_data_ff.key_time);
      span       = rd_data_ff.key_time - prev_ff.key_time;
      dt         = time_ff - prev_ff.key_time;
      start_math = (state_ff == ST_SCAN) && bracket && (span != '0);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      kcount_in    = kcount_ff;
      last_idx_in  = last_idx_ff;
      idx_in       = idx_ff;
      time_in      = time_ff;
      prev_in      = prev_ff;
      res_in       = res_ff;
      src_math_in  = src_math_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_z_in     = rsp_z_ff;
      rd_addr      = '0;

      if (csr_valid && csr_ready) begin
         kcount_in = csr_wdata;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept && (req_func == FUNC_SAMPLE)) begin
               time_in     = req_sample_time;
               last_idx_in = IDX_W'(count_eff - CNT_W'(1));
               state_in    = ST_FIRST;
            end
         end
         ST_FIRST: begin
            prev_in = rd_data_ff;
            if ((last_idx_ff == '0) || (time_ff <= rd_data_ff.key_time)) begin
               res_in      = rd_data_ff;
               src_math_in = 1'b0;
               state_in    = ST_HOLD;
            end else begin
               idx_in   = IDX_W'(1);
               rd_addr  = IDX_W'(1);
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_addr = idx_ff + IDX_W'(1);
            if (bracket) begin
               if (span == '0) begin
                  res_in      = prev_ff;
                  src_math_in = 1'b0;
                  state_in    = ST_HOLD;
               end else begin
                  state_in = ST_MATH;
               end
            end else if (idx_ff == last_idx_ff) begin
               res_in      = rd_data_ff;
               src_math_in = 1'b0;
               state_in    = ST_HOLD;
            end else begin
               prev_in = rd_data_ff;
               idx_in  = idx_ff + IDX_W'(1);
            end
         end
         ST_MATH: begin
            if (qdigit.step && qdigit.last) begin
               src_math_in = 1'b1;
               state_in    = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = src_math_ff ? lerp_x : res_ff.x;
               rsp_y_in     = src_math_ff ? lerp_y : res_ff.y;
               rsp_z_in     = src_math_ff ? lerp_z : res_ff.z;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         kcount_ff    <= KCOUNT_W'(1);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         kcount_ff    <= kcount_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      last_idx_ff <= last_idx_in;
      idx_ff      <= idx_in;
      time_ff     <= time_in;
      prev_ff     <= prev_in;
      res_ff      <= res_in;
      src_math_ff <= src_math_in;
      rsp_x_ff    <= rsp_x_in;
      rsp_y_ff    <= rsp_y_in;
      rsp_z_ff    <= rsp_z_in;
   end

   // fraction divider and component lerps
   ksl_divider u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (start_math),
      .dt     (dt),
      .span   (span),
      .qdigit (qdigit)
   );

   ksl_lerp u_lerp_x (
      .clock  (clock),
      .start  (start_math),
      .v0     ($signed(prev_ff.x)),
      .v1     ($signed(rd_data_ff.x)),
      .qdigit (qdigit),
      .result (lerp_x)
   );

   ksl_lerp u_lerp_y (
      .clock  (clock),
      .start  (start_math),
      .v0     ($signed(prev_ff.y)),
      .v1     ($signed(rd_data_ff.y)),
      .qdigit (qdigit),
      .result (lerp_y)
   );

   ksl_lerp u_lerp_z (
      .clock  (clock),
      .start  (start_math),
      .v0     ($signed(prev_ff.z)),
      .v1     ($signed(rd_data_ff.z)),
      .qdigit (qdigit),
      .result (lerp_z)
   );

   // response beat
   assign rsp_valid = rsp_valid_ff;
   assign rsp_out_x = $signed(rsp_x_ff);
   assign rsp_out_y = $signed(rsp_y_ff);
   assign rsp_out_z = $signed(rsp_z_ff);

endmodule

// File: rtl/core/ksl_divider.sv
// ----------------------------------------------------------------------------
// ksl_divider
// Bit-serial restoring divider: frac = floor(dt * 65536 / span), dt <= span,
// one quotient bit per cycle, most significant first.
// ----------------------------------------------------------------------------
module ksl_divider
   import ksl_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [WORD_W-1:0] dt,
   input  logic [WORD_W-1:0] span,
   output qdigit_type        qdigit
);

   logic              busy_ff, busy_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] span_ff, span_in;
   logic [FRAC_W-1:0] bits_ff, bits_in;

   logic [WORD_W:0]   shifted;
   logic              ge;
   logic              last;

   // trial subtract of the shifted remainder
   always_comb begin
      shifted = {rem_ff, bits_ff[FRAC_W-1]};
      ge      = shifted >= {1'b0, span_ff};
      last    = cnt_ff == QCNT_W'(FRAC_W - 1);
   end

   // next state of the iteration
   always_comb begin
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      span_in = span_ff;
      bits_in = bits_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = {1'b0, dt[WORD_W-1:1]};
         bits_in = {dt[0], {(FRAC_W-1){1'b0}}};
         span_in = span;
      end else if (busy_ff) begin
         cnt_in  = cnt_ff + QCNT_W'(1);
         bits_in = {bits_ff[FRAC_W-2:0], 1'b0};
         if (ge) begin
            rem_in = WORD_W'(shifted - {1'b0, span_ff});
         end else begin
            rem_in = shifted[WORD_W-1:0];
         end
         if (last) begin
            busy_in = 1'b0;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      span_ff <= span_in;
      bits_ff <= bits_in;
   end

   // digit beat toward the lerp units
   always_comb begin
      qdigit.step  = busy_ff;
      qdigit.digit = ge;
      qdigit.last  = last;
   end

endmodule

// File: rtl/core/ksl_lerp.sv
// ----------------------------------------------------------------------------
// ksl_lerp
// Serial lerp of one component: v0 + floor((v1 - v0) * frac / 65536), with
// the fraction taken in one bit per cycle, msb first, from the divider.
// ----------------------------------------------------------------------------
module ksl_lerp
   import ksl_pkg::*;
(
   input  logic                     clock,
   input  logic                     start,
   input  logic signed [WORD_W-1:0] v0,
   input  logic signed [WORD_W-1:0] v1,
   input  qdigit_type               qdigit,
   output logic signed [WORD_W-1:0] result
);

   logic [WORD_W-1:0] v0_ff, v0_in;
   logic [DIFF_W-1:0] diff_ff, diff_in;
   logic [ACC_W-1:0]  acc_ff, acc_in;
   logic [ACC_W-1:0]  addend;

   // shift-and-add of the signed difference
   always_comb begin
      v0_in   = v0_ff;
      diff_in = diff_ff;
      acc_in  = acc_ff;
      addend  = qdigit.digit ? {{(ACC_W-DIFF_W){diff_ff[DIFF_W-1]}}, diff_ff} : '0;
      if (start) begin
         v0_in   = v0;
         diff_in = {v1[WORD_W-1], v1} - {v0[WORD_W-1], v0};
         acc_in  = '0;
      end else if (qdigit.step) begin
         acc_in  = {acc_ff[ACC_W-2:0], 1'b0} + addend;
      end
   end

   always_ff @(posedge clock) begin
      v0_ff   <= v0_in;
      diff_ff <= diff_in;
      acc_ff  <= acc_in;
   end

   // arithmetic shift by 16 floors, only the low word is kept
   assign result = $signed(v0_ff + acc_ff[ACC_W-1:FRAC_W-1]);

endmodule
